// File: src/rsm_pkg.sv
// Shared constants and types for the rotating stereo mixer.
package rsm_pkg;

    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // Width of the phase increment register.
    localparam int INC_W = 32;

    // Coefficients are Q1.24; the table peak is exactly 1.0 and needs 25 bits.
    localparam int COEF_FRAC = 24;
    localparam int COEF_W    = COEF_FRAC + 1;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_status_t;

endpackage

// File: src/rsm_front.sv
// Front end: phase accumulator, increment register and angle classification.
module rsm_front #(
    parameter int SAMPLE_BITS     = rsm_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS      = rsm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = rsm_pkg::TABLE_ADDR_BITS_DEF,
    parameter int ENTRY_W         = 2 + TABLE_ADDR_BITS + 2 * SAMPLE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic signed [rsm_pkg::INC_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]   s_right_sample,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [ENTRY_W-1:0]              q_entry
);
    import rsm_pkg::*;

    localparam int ADDR_W = TABLE_ADDR_BITS + 2;

    logic        [PHASE_BITS-1:0]        phase_reg;
    logic        [PHASE_BITS-1:0]        phase_next;
    logic signed [INC_W-1:0]             inc_reg;
    logic        [PHASE_BITS-1:0]        inc_ext;
    logic        [PHASE_BITS+ADDR_W-1:0] phase_pad;
    logic        [ADDR_W-1:0]            table_addr;

    // Padding below the phase covers a phase narrower than the table address.
    assign phase_pad  = {phase_reg, ADDR_W'(0)};
    assign table_addr = phase_pad[PHASE_BITS+ADDR_W-1 -: ADDR_W];

    assign inc_ext    = PHASE_BITS'(inc_reg);
    assign phase_next = phase_reg + inc_ext;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign q_entry = {table_addr, s_left_sample, s_right_sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            inc_reg   <= '0;
        end else begin
            if (cfg_we) begin
                inc_reg <= cfg_wdata;
            end
            if (q_push) begin
                phase_reg <= phase_next;
            end
        end
    end

endmodule

// File: src/rsm_queue.sv
// Small FIFO that decouples the front end from the arithmetic back end.
module rsm_queue #(
    parameter int ENTRY_W = 2 + rsm_pkg::TABLE_ADDR_BITS_DEF + 2 * rsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    input  logic               pop,
    output logic [ENTRY_W-1:0] pop_data,
    output rsm_pkg::q_status_t status
);
    import rsm_pkg::*;

    logic [ENTRY_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    assign do_push  = push && !status.full;
    assign do_pop   = pop && !status.empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/rsm_back.sv
// Back end: sine table lookup, four multipliers, rounding and saturation.
module rsm_back #(
    parameter int SAMPLE_BITS     = rsm_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = rsm_pkg::TABLE_ADDR_BITS_DEF,
    parameter int ENTRY_W         = 2 + TABLE_ADDR_BITS + 2 * SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  logic [ENTRY_W-1:0]            q_entry,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);
    import rsm_pkg::*;

    localparam int TABLE_N = 1 << TABLE_ADDR_BITS;
    localparam int IDX_W   = TABLE_ADDR_BITS + 1;
    localparam int CW      = COEF_W + 1;
    localparam int PW      = SAMPLE_BITS + CW;
    localparam int SW      = PW + 1;
    localparam int QW      = SW - COEF_FRAC;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic signed [QW-1:0] SAT_HI = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);
    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (COEF_FRAC - 1);

    typedef logic [COEF_W-1:0] rom_t [TABLE_N+1];

    // Entry k is sin(pi/2 * k / N) in Q1.24, from a truncated Taylor series in Q2.30.
    function automatic logic [COEF_W-1:0] sine_q24(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (PI_HALF_Q30 * 64'(k) + (64'd1 << (TABLE_ADDR_BITS - 1))) >> TABLE_ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        return COEF_W'((sum + 64'sd32) >>> 6);
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k <= TABLE_N; k++) begin
            t[k] = sine_q24(k);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Queue entry fields.
    logic        [1:0]                 in_quad;
    logic        [TABLE_ADDR_BITS-1:0] in_idx;
    logic signed [SAMPLE_BITS-1:0]     in_left;
    logic signed [SAMPLE_BITS-1:0]     in_right;

    // Stage 1: table read.
    logic                          v1_reg;
    logic        [COEF_W-1:0]      a_reg;
    logic        [COEF_W-1:0]      b_reg;
    logic        [1:0]             quad1_reg;
    logic signed [SAMPLE_BITS-1:0] left1_reg;
    logic signed [SAMPLE_BITS-1:0] right1_reg;

    // Stage 2: products.
    logic                 v2_reg;
    logic signed [PW-1:0] lc_reg;
    logic signed [PW-1:0] rs_reg;
    logic signed [PW-1:0] rc_reg;
    logic signed [PW-1:0] ls_reg;

    // Stage 3: output register.
    logic                          v3_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    logic                 load1;
    logic                 load2;
    logic                 load3;
    logic [IDX_W-1:0]     idx_a;
    logic [IDX_W-1:0]     idx_b;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] sin_val;
    logic signed [CW-1:0] cos_val;
    logic signed [SW-1:0] sum_l;
    logic signed [SW-1:0] sum_r;
    logic signed [QW-1:0] q_l;
    logic signed [QW-1:0] q_r;
    logic signed [SAMPLE_BITS-1:0] sat_l;
    logic signed [SAMPLE_BITS-1:0] sat_r;

    assign {in_quad, in_idx, in_left, in_right} = q_entry;

    // Each stage loads when it is empty or its contents move on.
    assign load3 = v2_reg && (!v3_reg || m_ready);
    assign load2 = v1_reg && (!v2_reg || load3);
    assign load1 = q_valid && (!v1_reg || load2);
    assign q_pop = load1;

    assign idx_a = IDX_W'(in_idx);
    assign idx_b = IDX_W'(TABLE_N) - IDX_W'(in_idx);

    assign coef_a = signed'({1'b0, a_reg});
    assign coef_b = signed'({1'b0, b_reg});

    always_comb begin
        unique case (quad_t'(quad1_reg))
            QUAD_0: begin
                sin_val = coef_a;
                cos_val = coef_b;
            end
            QUAD_1: begin
                sin_val = coef_b;
                cos_val = -coef_a;
            end
            QUAD_2: begin
                sin_val = -coef_a;
                cos_val = -coef_b;
            end
            QUAD_3: begin
                sin_val = -coef_b;
                cos_val = coef_a;
            end
            default: begin
                sin_val = coef_a;
                cos_val = coef_b;
            end
        endcase
    end

    // Round half up by the coefficient fraction, then clamp.
    assign sum_l = SW'(lc_reg) + SW'(rs_reg) + HALF_LSB;
    assign sum_r = SW'(rc_reg) - SW'(ls_reg) + HALF_LSB;
    assign q_l   = sum_l[SW-1:COEF_FRAC];
    assign q_r   = sum_r[SW-1:COEF_FRAC];

    always_comb begin
        if (q_l > SAT_HI) begin
            sat_l = SAT_HI[SAMPLE_BITS-1:0];
        end else if (q_l < SAT_LO) begin
            sat_l = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_l = q_l[SAMPLE_BITS-1:0];
        end
        if (q_r > SAT_HI) begin
            sat_r = SAT_HI[SAMPLE_BITS-1:0];
        end else if (q_r < SAT_LO) begin
            sat_r = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_r = q_r[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            a_reg      <= SINE_ROM[idx_a];
            b_reg      <= SINE_ROM[idx_b];
            quad1_reg  <= in_quad;
            left1_reg  <= in_left;
            right1_reg <= in_right;
        end
        if (load2) begin
            lc_reg <= left1_reg * cos_val;
            rs_reg <= right1_reg * sin_val;
            rc_reg <= right1_reg * cos_val;
            ls_reg <= left1_reg * sin_val;
        end
        if (load3) begin
            left_out_reg  <= sat_l;
            right_out_reg <= sat_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (load1) begin
                v1_reg <= 1'b1;
            end else if (load2) begin
                v1_reg <= 1'b0;
            end
            if (load2) begin
                v2_reg <= 1'b1;
            end else if (load3) begin
                v2_reg <= 1'b0;
            end
            if (load3) begin
                v3_reg <= 1'b1;
            end else if (m_ready) begin
                v3_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = v3_reg;
    assign m_left_out  = left_out_reg;
    assign m_right_out = right_out_reg;

endmodule

// File: src/rotating_stereo_mixer.sv
// Top level of the rotating stereo mixer: front end, queue and arithmetic back end.
//
// Each input item is one stereo pair (s_left_sample, s_right_sample) in signed Q1.23.
// The block rotates the pair by the current phase angle and returns one result item
// (m_left_out, m_right_out), rounded half up and saturated to the sample range.
// After each accepted item the phase accumulator advances by the signed value in the
// phase increment register, wrapping modulo one turn in either direction.
// The user must write the increment register through cfg_we / cfg_wdata only while
// the block is idle; the block does not enforce this. Both channels use valid/ready;
// an item moves on a clock edge where both are high. Throughput is one item per clock
// while the receiver does not stall: the phase accumulator is the only state carried
// from item to item and it needs a single add. With an empty queue, the item is
// written into the queue at the accepting edge, then goes through the registered sine
// table read, the multipliers, and rounding and saturation into the output register.
// When the receiver stalls, the back end pipeline fills, then the four-entry queue
// fills, and only then does s_ready fall; the front keeps taking items meanwhile.
// Synchronous active-low reset clears the phase, the increment, the queue and all
// valid flags; the sine table is a constant ROM and needs no initialization pass.
module rotating_stereo_mixer #(
    parameter int SAMPLE_BITS     = rsm_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS      = rsm_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = rsm_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic signed [rsm_pkg::INC_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]    s_right_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_left_out,
    output logic signed [SAMPLE_BITS-1:0]    m_right_out
);
    import rsm_pkg::*;

    // A queue entry holds the quadrant, the table index and both samples.
    localparam int ENTRY_W = 2 + TABLE_ADDR_BITS + 2 * SAMPLE_BITS;

    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_pop_data;
    q_status_t          q_status;

    // The front classifies each item by its phase and pushes it into the queue.
    rsm_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .ENTRY_W         (ENTRY_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .q_full         (q_status.full),
        .q_push         (q_push),
        .q_entry        (q_push_data)
    );

    rsm_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // The back end drains the queue whenever its first stage can take an item.
    rsm_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .ENTRY_W         (ENTRY_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (!q_status.empty),
        .q_entry     (q_pop_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

`ifndef SYNTHESIS
    // Input is refused only when the queue is completely full.
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (q_status.count == QCNT_W'(QUEUE_DEPTH)))
        else $error("s_ready low while the queue has room");

    // The back end never pulls from an empty queue.
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // Queue occupancy tracks pushes and pops exactly.
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (q_status.count ==
            $past(q_status.count) + QCNT_W'($past(q_push)) - QCNT_W'($past(q_pop))))
        else $error("queue count out of step with push and pop");

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");
`endif

endmodule
